[hdl/ebsa_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the slot allocator.
package ebsa_pkg;

    localparam int BLOCKS_DEF = 64;
    localparam int SLOTS_DEF  = 32;

    // payload field widths
    localparam int TGT_W   = 6;
    localparam int ST_W    = 2;
    localparam int GB_W    = 6;
    localparam int GS_W    = 5;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;
    localparam int OUT_PAD = OUT_W - ST_W - GB_W - GS_W - 1;

    // request kinds
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_LIVE  = 2'd2;

    typedef struct packed {
        logic init_step;
        logic accept;
        logic alloc_open;
        logic alloc_fail;
        logic alloc_live_rd;
        logic alloc_inc;
        logic rm_reject;
        logic rm_dec;
        logic rm_ok;
        logic scan_start;
        logic scan_rd;
        logic scan_next;
        logic hit_rd;
        logic rm_free;
    } ebsa_cmd_t;

    typedef struct packed {
        logic init_last;
        logic open_needed;
        logic pool_empty;
        logic tgt_bad;
        logic live_zero;
        logic live_one;
        logic scan_end;
        logic hit;
        logic out_free;
    } ebsa_sts_t;

endpackage

[hdl/ebsa_dp.sv]
// Allocator datapath: free stack, active list, live counts, counters and result register.
module ebsa_dp #(
    parameter int BLOCKS = ebsa_pkg::BLOCKS_DEF,
    parameter int SLOTS  = ebsa_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ebsa_pkg::ebsa_cmd_t         cmd,
    output ebsa_pkg::ebsa_sts_t         sts,
    input  logic [ebsa_pkg::TGT_W-1:0]  s_target,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ebsa_pkg::OUT_W-1:0]  m_tdata
);
    import ebsa_pkg::*;

    localparam int ID_W  = $clog2(BLOCKS);
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int U_W   = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [ID_W-1:0] blk;
        logic [U_W-1:0]  used;
    } act_ent_t;

    // memories
    act_ent_t        act_mem  [BLOCKS];
    logic [ID_W-1:0] fs_mem   [BLOCKS];
    logic [U_W-1:0]  live_mem [BLOCKS];

    // registered read data
    act_ent_t        act_rd_reg;
    logic [ID_W-1:0] fs_rd_reg;
    logic [U_W-1:0]  live_rd_reg;

    // control registers
    logic [CNT_W-1:0] free_top_reg, free_top_next;
    logic [CNT_W-1:0] act_cnt_reg, act_cnt_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [ID_W-1:0]  init_idx_reg, init_idx_next;
    logic [TGT_W-1:0] req_tgt_reg;
    logic             m_tvalid_reg, m_tvalid_next;

    // result payload
    logic [ST_W-1:0] status_reg, status_next;
    logic [GB_W-1:0] gblock_reg, gblock_next;
    logic [GS_W-1:0] gslot_reg, gslot_next;
    logic            freed_reg, freed_next;

    logic [ID_W-1:0] act_last, tgt_id;
    logic            push_ok, emit;

    logic            act_we, act_re, fs_we, live_we, live_re;
    logic [ID_W-1:0] act_wa, act_ra, fs_wa, fs_wd, fs_ra, live_wa, live_ra;
    act_ent_t        act_wd;
    logic [U_W-1:0]  live_wd;

    assign act_last = ID_W'(act_cnt_reg - CNT_W'(1));
    assign tgt_id   = ID_W'(req_tgt_reg);
    assign push_ok  = free_top_reg < CNT_W'(BLOCKS);
    assign emit     = cmd.alloc_open | cmd.alloc_fail | cmd.alloc_inc |
                      cmd.rm_reject | cmd.rm_ok | cmd.rm_free;

    // active list port
    always_comb begin
        act_we = cmd.alloc_open | cmd.alloc_inc | cmd.rm_free;
        act_re = cmd.accept | cmd.scan_rd | cmd.hit_rd;
        act_ra = cmd.scan_rd ? scan_idx_reg[ID_W-1:0] : act_last;
        priority if (cmd.alloc_open) begin
            act_wa = ID_W'(act_cnt_reg);
            act_wd = '{blk: fs_rd_reg, used: U_W'(1)};
        end else if (cmd.alloc_inc) begin
            act_wa = act_last;
            act_wd = '{blk: act_rd_reg.blk, used: act_rd_reg.used + U_W'(1)};
        end else begin
            // swap-and-pop: the last entry moves into the hit position
            act_wa = scan_idx_reg[ID_W-1:0];
            act_wd = act_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[act_wa] <= act_wd;
        end
        if (act_re) begin
            act_rd_reg <= act_mem[act_ra];
        end
    end

    // free stack port
    always_comb begin
        fs_we = cmd.init_step | (cmd.rm_free & push_ok);
        fs_wa = cmd.init_step ? init_idx_reg : ID_W'(free_top_reg);
        fs_wd = cmd.init_step ? init_idx_reg : tgt_id;
        fs_ra = ID_W'(free_top_reg - CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[fs_wa] <= fs_wd;
        end
        if (cmd.accept) begin
            fs_rd_reg <= fs_mem[fs_ra];
        end
    end

    // live count port
    always_comb begin
        live_we = cmd.init_step | cmd.alloc_open | cmd.alloc_inc | cmd.rm_dec;
        live_re = cmd.accept | cmd.alloc_live_rd;
        live_ra = cmd.accept ? ID_W'(s_target) : act_rd_reg.blk;
        priority if (cmd.init_step) begin
            live_wa = init_idx_reg;
            live_wd = '0;
        end else if (cmd.alloc_open) begin
            live_wa = fs_rd_reg;
            live_wd = U_W'(1);
        end else if (cmd.alloc_inc) begin
            live_wa = act_rd_reg.blk;
            live_wd = live_rd_reg + U_W'(1);
        end else begin
            live_wa = tgt_id;
            live_wd = live_rd_reg - U_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (live_we) begin
            live_mem[live_wa] <= live_wd;
        end
        if (live_re) begin
            live_rd_reg <= live_mem[live_ra];
        end
    end

    // counters
    always_comb begin
        free_top_next = free_top_reg;
        act_cnt_next  = act_cnt_reg;
        scan_idx_next = scan_idx_reg;
        init_idx_next = init_idx_reg;
        if (cmd.init_step) begin
            init_idx_next = init_idx_reg + ID_W'(1);
        end
        if (cmd.alloc_open) begin
            free_top_next = free_top_reg - CNT_W'(1);
            act_cnt_next  = act_cnt_reg + CNT_W'(1);
        end
        if (cmd.rm_free) begin
            act_cnt_next = act_cnt_reg - CNT_W'(1);
            if (push_ok) begin
                free_top_next = free_top_reg + CNT_W'(1);
            end
        end
        if (cmd.scan_start) begin
            scan_idx_next = '0;
        end else if (cmd.scan_next) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_top_reg <= CNT_W'(BLOCKS);
            act_cnt_reg  <= '0;
            scan_idx_reg <= '0;
            init_idx_reg <= '0;
        end else begin
            free_top_reg <= free_top_next;
            act_cnt_reg  <= act_cnt_next;
            scan_idx_reg <= scan_idx_next;
            init_idx_reg <= init_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_tgt_reg <= s_target;
        end
    end

    // result register
    always_comb begin
        status_next = ST_OK;
        gblock_next = '0;
        gslot_next  = '0;
        freed_next  = 1'b0;
        if (cmd.alloc_open) begin
            gblock_next = GB_W'(fs_rd_reg);
        end
        if (cmd.alloc_inc) begin
            gblock_next = GB_W'(act_rd_reg.blk);
            gslot_next  = GS_W'(act_rd_reg.used);
        end
        if (cmd.alloc_fail) begin
            status_next = ST_EXHAUSTED;
        end
        if (cmd.rm_reject) begin
            status_next = ST_NOT_LIVE;
        end
        if (cmd.rm_free) begin
            freed_next = 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            status_reg <= status_next;
            gblock_reg <= gblock_next;
            gslot_reg  <= gslot_next;
            freed_reg  <= freed_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OUT_PAD'(0), freed_reg, gslot_reg, gblock_reg, status_reg};

    // status to the controller
    always_comb begin
        sts.init_last   = init_idx_reg == ID_W'(BLOCKS - 1);
        sts.open_needed = (act_cnt_reg == '0) || (32'(act_rd_reg.used) >= SLOTS);
        sts.pool_empty  = (free_top_reg == '0) || (act_cnt_reg >= CNT_W'(BLOCKS));
        sts.tgt_bad     = 32'(req_tgt_reg) >= BLOCKS;
        sts.live_zero   = live_rd_reg == '0;
        sts.live_one    = live_rd_reg == U_W'(1);
        sts.scan_end    = scan_idx_reg >= act_cnt_reg;
        sts.hit         = act_rd_reg.blk == tgt_id;
        sts.out_free    = !m_tvalid_reg || m_tready;
    end

endmodule

[hdl/ebsa_ctrl.sv]
// Allocator controller: sequences init sweep, allocate, remove and active-list search.
module ebsa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_req,
    output logic                s_tready,
    output ebsa_pkg::ebsa_cmd_t cmd,
    input  ebsa_pkg::ebsa_sts_t sts
);
    import ebsa_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_A_RD   = 3'd2;
    localparam logic [2:0] ST_A_INC  = 3'd3;
    localparam logic [2:0] ST_R_CHK  = 3'd4;
    localparam logic [2:0] ST_S_RD   = 3'd5;
    localparam logic [2:0] ST_S_CMP  = 3'd6;
    localparam logic [2:0] ST_S_SWAP = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_req == REQ_REMOVE) ? ST_R_CHK : ST_A_RD;
                end
            end
            ST_A_RD: begin
                if (!sts.open_needed) begin
                    cmd.alloc_live_rd = 1'b1;
                    state_next        = ST_A_INC;
                end else if (sts.out_free) begin
                    cmd.alloc_fail = sts.pool_empty;
                    cmd.alloc_open = !sts.pool_empty;
                    state_next     = ST_IDLE;
                end
            end
            ST_A_INC: begin
                if (sts.out_free) begin
                    cmd.alloc_inc = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_R_CHK: begin
                if (sts.tgt_bad || sts.live_zero) begin
                    if (sts.out_free) begin
                        cmd.rm_reject = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (sts.live_one) begin
                    // last entity gone: find the block in the active list
                    cmd.rm_dec     = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_S_RD;
                end else if (sts.out_free) begin
                    cmd.rm_dec = 1'b1;
                    cmd.rm_ok  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD: begin
                if (sts.scan_end) begin
                    if (sts.out_free) begin
                        cmd.rm_ok  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                if (sts.hit) begin
                    cmd.hit_rd = 1'b1;
                    state_next = ST_S_SWAP;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_S_RD;
                end
            end
            ST_S_SWAP: begin
                if (sts.out_free) begin
                    cmd.rm_free = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/entity_block_slot_allocator_top.sv]
// Entity block slot allocator: a remove, or an allocate that opens a block, is decided in
// the state after the accept; an allocate into the last block first reads the block's live count,
// and a remove that frees a block first searches the active list for it, entry by entry.
// One request at a time; the next beat is taken the cycle after the result is registered,
// the rate being set by the registered reads of the list and count memories.
// After aresetn a sweep loads the free stack and clears live counts; tready low.
module entity_block_slot_allocator_top #(
    parameter int BLOCKS = ebsa_pkg::BLOCKS_DEF,
    parameter int SLOTS  = ebsa_pkg::SLOTS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ebsa_pkg::IN_W-1:0]  s_tdata,  // [5:0] target_block
    input  logic [0:0]                 s_tuser,  // [0] req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ebsa_pkg::OUT_W-1:0] m_tdata   // [1:0] status, [7:2] granted_block,
                                                 // [12:8] granted_slot, [13] block_freed
);
    import ebsa_pkg::*;

    ebsa_cmd_t cmd;
    ebsa_sts_t sts;

    ebsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_req    (s_tuser[0]),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ebsa_dp #(
        .BLOCKS (BLOCKS),
        .SLOTS  (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_target (s_tdata[TGT_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/ebsa_chk.sv]
// Port-level checker for the slot allocator and its bind to the top level.
module ebsa_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ebsa_pkg::OUT_W-1:0] m_tdata
);
    import ebsa_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_EXHAUSTED ||
                      m_tdata[1:0] == ST_NOT_LIVE))
        else $error("undefined status code");

    // a failed request grants nothing and frees nothing
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[13:2] == '0)
        else $error("failed request carries grant or free");

    // a free comes only from a successful remove, which grants nothing
    a_freed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[1:0] == ST_OK && m_tdata[12:2] == '0)
        else $error("block free on a non-remove result");

    // one request in flight at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

endmodule

bind entity_block_slot_allocator_top ebsa_chk u_ebsa_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/tb_entity_block_slot_allocator_top.sv]
// Self-checking stream testbench for the entity block slot allocator.
module tb_entity_block_slot_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ebsa_pkg::*;

    localparam int NUM_BLOCKS  = BLOCKS_DEF;
    localparam int NUM_SLOTS   = SLOTS_DEF;
    localparam int RAND_ITEMS  = 300;
    localparam int CYCLE_LIMIT = 3_000_000;

    // request beat and grant, grant laid out as in m_tdata (status in the low bits)
    typedef struct packed {
        logic             req;
        logic [TGT_W-1:0] tgt;
    } req_beat_t;

    typedef struct packed {
        logic            freed;
        logic [GS_W-1:0] slot;
        logic [GB_W-1:0] blk;
        logic [ST_W-1:0] status;
    } grant_t;

    typedef struct {
        req_beat_t beat;
        grant_t    want;
        bit        sync;  // hold this beat until all earlier grants are back
    } pending_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;  // [5:0] target_block
    logic [0:0]       s_tuser  = '0;  // [0] req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // [1:0] status, [7:2] granted_block,
                                      // [12:8] granted_slot, [13] block_freed

    entity_block_slot_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // allocator shadow state
    bit [GB_W-1:0] pool_stack [NUM_BLOCKS];
    bit [6:0]      pool_top;
    bit [GB_W-1:0] act_blk    [NUM_BLOCKS];
    bit [5:0]      act_used   [NUM_BLOCKS];
    bit [6:0]      act_cnt;
    bit [5:0]      blk_live   [NUM_BLOCKS];

    pending_t  req_q[$];
    grant_t    grant_q[$];
    pending_t  cur;
    bit        beat_live  = 1'b0;
    logic      fire_q     = 1'b0;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        n_gen      = 0;
    int        n_taken    = 0;
    int        n_err      = 0;
    int        n_cyc      = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;
    int        rx_mode    = 0;
    int        rx_left    = 0;

    function automatic bit pool_pop_block();
        bit [GB_W-1:0] b;
        if (pool_top == 0 || act_cnt >= NUM_BLOCKS) return 1'b0;
        pool_top = pool_top - 1;
        b = pool_stack[pool_top];
        act_blk[act_cnt]  = b;
        act_used[act_cnt] = '0;
        blk_live[b]       = '0;
        act_cnt = act_cnt + 1;
        return 1'b1;
    endfunction

    function automatic grant_t slot_alloc_predict(input req_beat_t beat);
        grant_t        r;
        bit            ok;
        int            last;
        int            used;
        bit [GB_W-1:0] b;
        bit [GB_W-1:0] tb;
        bit [5:0]      tu;
        r = '0;
        if (beat.req == REQ_ALLOC) begin
            ok = 1'b1;
            if (act_cnt == 0) ok = pool_pop_block();
            if (ok) begin
                last = act_cnt - 1;
                used = act_used[last];
                // full (or overfull) last block: open a fresh one
                if (used >= NUM_SLOTS) begin
                    ok   = pool_pop_block();
                    last = act_cnt - 1;
                    used = 0;
                end
            end
            if (ok) begin
                b = act_blk[last];
                blk_live[b]    = blk_live[b] + 1;
                act_used[last] = 6'(used + 1);
                r.blk  = b;
                r.slot = GS_W'(used);
            end else begin
                r.status = ST_EXHAUSTED;
            end
        end else begin
            b = beat.tgt;
            if (blk_live[b] == 0) begin
                r.status = ST_NOT_LIVE;
            end else begin
                blk_live[b] = blk_live[b] - 1;
                if (blk_live[b] == 0) begin
                    for (int i = 0; i < act_cnt; i++) begin
                        if (act_blk[i] == b) begin
                            last = act_cnt - 1;
                            tb = act_blk[last];
                            tu = act_used[last];
                            act_blk[last]  = act_blk[i];
                            act_used[last] = act_used[i];
                            act_blk[i]     = tb;
                            act_used[i]    = tu;
                            act_cnt = act_cnt - 1;
                            if (pool_top < NUM_BLOCKS) begin
                                pool_stack[pool_top] = b;
                                pool_top = pool_top + 1;
                            end
                            r.freed = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic push_req(input bit rq, input int tgt, input bit sync);
        pending_t p;
        p.beat.req = rq;
        p.beat.tgt = tgt[TGT_W-1:0];
        p.want     = slot_alloc_predict(p.beat);
        p.sync     = sync;
        req_q = {req_q, p};
        n_gen++;
    endtask

    // random block that still holds live entities, -1 if none
    function automatic int pick_live();
        int ids[$];
        for (int b = 0; b < NUM_BLOCKS; b++)
            if (blk_live[b] != 0) ids = {ids, b};
        if (ids.size() == 0) return -1;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            n_err++;
        end
    endtask

    // driver: one beat in flight, bursts with random gaps
    always @(negedge aclk) begin
        if (fire_q) beat_live = 1'b0;
        if (aresetn && !beat_live) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0 && !(req_q[0].sync && grant_q.size() > 0)) begin
                cur = req_q.pop_front();
                beat_live = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_tvalid <= beat_live;
        s_tdata  <= {{(IN_W - TGT_W){1'b0}}, cur.beat.tgt};
        s_tuser  <= cur.beat.req;
    end

    always @(posedge aclk) begin
        fire_q <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            grant_q = {grant_q, cur.want};
            n_taken++;
        end
    end

    // receiver: mode pattern, plus one long hold-off while the sender keeps offering
    always @(negedge aclk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && n_taken >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
            rdy = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            case (rx_mode)
                0: begin
                    rdy = 1'b1;
                end
                1: begin
                    rdy = 1'($urandom_range(0, 1));
                end
                default: begin
                    rdy = ($urandom_range(0, 5) == 0);
                end
            endcase
        end
        m_tready <= rdy;
    end

    // monitor
    always @(posedge aclk) begin
        grant_t want;
        grant_t got;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = grant_t'(m_tdata[$bits(grant_t)-1:0]);
            if (grant_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, got %h", $time, m_tdata);
                n_err++;
            end else begin
                want = grant_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("granted_block", want.blk, got.blk);
                check_field("granted_slot", want.slot, got.slot);
                check_field("block_freed", want.freed, got.freed);
            end
        end
    end

    always @(posedge aclk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc == CYCLE_LIMIT) begin
            $display("tb_entity_block_slot_allocator_top: FAIL");
            $finish;
        end
    end

    initial begin
        int n_exh;
        int n_rand;
        int b;
        int r;
        int kind;
        int len;

        for (int i = 0; i < NUM_BLOCKS; i++) begin
            pool_stack[i] = GB_W'(i);
            blk_live[i]   = '0;
            act_blk[i]    = '0;
            act_used[i]   = '0;
        end
        pool_top = NUM_BLOCKS;
        act_cnt  = '0;

        // directed: idle removes, first open, partial and full drain, reopen
        push_req(REQ_REMOVE, 0, 0);
        push_req(REQ_REMOVE, 63, 0);
        push_req(REQ_ALLOC, 63, 0);
        push_req(REQ_ALLOC, 0, 0);
        push_req(REQ_REMOVE, 63, 0);
        push_req(REQ_REMOVE, 63, 0);
        push_req(REQ_REMOVE, 63, 0);
        push_req(REQ_REMOVE, 6'h2A, 0);
        push_req(REQ_REMOVE, 6'h15, 0);
        push_req(REQ_ALLOC, 6'h2A, 0);
        push_req(REQ_ALLOC, 6'h15, 0);
        push_req(REQ_REMOVE, 62, 0);

        // fill the whole pool until allocates come back exhausted
        n_exh = 0;
        push_req(REQ_ALLOC, $urandom_range(0, 63), 1);
        while (n_exh < 3) begin
            r = $urandom_range(0, 99);
            b = pick_live();
            if (r < 3 && b >= 0) begin
                push_req(REQ_REMOVE, b, 0);
            end else if (r < 5) begin
                push_req(REQ_REMOVE, $urandom_range(0, 63), 0);
            end else begin
                push_req(REQ_ALLOC, $urandom_range(0, 63), 0);
                if (req_q[$].want.status == ST_EXHAUSTED) n_exh++;
            end
        end

        // empty a batch of blocks so they go back to the pool from deep list positions
        repeat (6) begin
            b = pick_live();
            if (b >= 0)
                while (blk_live[b] != 0) push_req(REQ_REMOVE, b, 0);
        end

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                push_req(REQ_ALLOC, $urandom_range(0, 63), 1);
                n_rand++;
            end else if (kind < 7) begin
                b = pick_live();
                if (b >= 0)
                    while (blk_live[b] != 0) begin
                        push_req(REQ_REMOVE, b, 0);
                        n_rand++;
                    end
            end else if (kind < 9) begin
                len = $urandom_range(3, 12);
                repeat (len) begin
                    push_req(1'($urandom_range(0, 1)), $urandom_range(0, 63), 0);
                    n_rand++;
                end
            end else begin
                len = $urandom_range(10, 50);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    b = pick_live();
                    if (r < 60 || (r < 90 && b < 0))
                        push_req(REQ_ALLOC, $urandom_range(0, 63), 0);
                    else if (r < 90)
                        push_req(REQ_REMOVE, b, 0);
                    else
                        push_req(REQ_REMOVE, $urandom_range(0, 63), 0);
                    n_rand++;
                end
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_taken != n_gen) @(posedge aclk);
        while (grant_q.size() != 0) @(posedge aclk);
        // longest free scan plus margin for any stray beat
        repeat (200) @(posedge aclk);
        if (n_err == 0)
            $display("tb_entity_block_slot_allocator_top: PASS");
        else
            $display("tb_entity_block_slot_allocator_top: FAIL");
        $finish;
    end

endmodule
